/* design/i64div_pkg.sv */
// Shared widths and payload types for the 64-bit integer divider.
package i64div_pkg;

  localparam int unsigned DivW = 64;
  localparam int unsigned CntW = $clog2(DivW);

  typedef struct packed {
    logic            req_type;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } req_t;

  typedef struct packed {
    logic [DivW-1:0] quotient;
    logic [DivW-1:0] remainder_out;
    logic            div_by_zero;
  } rsp_t;

endpackage

/* design/i64div_if.sv */
// Valid/ready channel interfaces for divider requests and responses.
interface i64div_req_if;
  import i64div_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i64div_rsp_if;
  import i64div_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/int64_divider_signed_unsigned.sv */
// 64-bit signed/unsigned restoring divider with a shared subtract unit.
// Requests are taken only while idle; each runs 64 divide steps, then a sign-fix state
// that loads the output register; a zero divisor goes straight to sign-fix. A new word
// is taken only once the last has loaded the output register. The single 65-bit
// subtractor produces one quotient bit per cycle; a held response does not block
// taking the next request but stalls its sign-fix. Reset (rst_ni low, asynchronous)
// clears the sequencer and the response valid; data registers are not reset.
module int64_divider_signed_unsigned (
  input logic         clk_i,
  input logic         rst_ni,
  i64div_req_if.sink  req_i,
  i64div_rsp_if.source rsp_o
);
  import i64div_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StFix  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] aq_q, aq_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic            neg_q_q, neg_q_d;
  logic            neg_r_q, neg_r_d;
  logic            dbz_q, dbz_d;
  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_data_q, rsp_data_d;

  logic            neg_a, neg_b;
  logic [DivW-1:0] mag_a, mag_b;
  logic [DivW-1:0] shifted;
  logic [DivW:0]   diff;
  logic            fits;

  assign neg_a = req_i.data.req_type & req_i.data.dividend[DivW-1];
  assign neg_b = req_i.data.req_type & req_i.data.divisor[DivW-1];
  assign mag_a = neg_a ? ('0 - req_i.data.dividend) : req_i.data.dividend;
  assign mag_b = neg_b ? ('0 - req_i.data.divisor) : req_i.data.divisor;

  assign shifted = {rem_q[DivW-2:0], aq_q[DivW-1]};
  assign diff    = {rem_q[DivW-1], shifted} - {1'b0, dvs_q};
  assign fits    = ~diff[DivW];

  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    aq_d        = aq_q;
    dvs_d       = dvs_q;
    neg_q_d     = neg_q_q;
    neg_r_d     = neg_r_q;
    dbz_d       = dbz_q;
    rsp_valid_d = rsp_valid_q;
    rsp_data_d  = rsp_data_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          cnt_d = '0;
          rem_d = '0;
          dvs_d = mag_b;
          if (req_i.data.divisor == '0) begin
            aq_d    = '0;
            neg_q_d = 1'b0;
            neg_r_d = 1'b0;
            dbz_d   = 1'b1;
            state_d = StFix;
          end else begin
            aq_d    = mag_a;
            neg_q_d = neg_a ^ neg_b;
            neg_r_d = neg_a;
            dbz_d   = 1'b0;
            state_d = StRun;
          end
        end
      end
      StRun: begin
        rem_d = fits ? diff[DivW-1:0] : shifted;
        aq_d  = {aq_q[DivW-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          state_d = StFix;
        end
      end
      StFix: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d              = 1'b1;
          rsp_data_d.quotient      = neg_q_q ? ('0 - aq_q) : aq_q;
          rsp_data_d.remainder_out = neg_r_q ? ('0 - rem_q) : rem_q;
          rsp_data_d.div_by_zero   = dbz_q;
          state_d                  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    aq_q       <= aq_d;
    dvs_q      <= dvs_d;
    neg_q_q    <= neg_q_d;
    neg_r_q    <= neg_r_d;
    dbz_q      <= dbz_d;
    rsp_data_q <= rsp_data_d;
  end

endmodule

/* design/i64div_checker.sv */
// Port-level assertions for the divider and their bind to the top level.
module i64div_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input i64div_pkg::rsp_t      rsp_data_i
);
  import i64div_pkg::*;

  logic req_acc, rsp_acc;
  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // hold ready low in the cycle after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("divider ready too soon after accepting a word");

  // zero divisor flags come with zero results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_data_i.div_by_zero) |->
      (rsp_data_i.quotient == '0 && rsp_data_i.remainder_out == '0))
    else $error("divide-by-zero word with nonzero results");

  // no new response right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (!rsp_valid_i || rsp_acc)) |=> !rsp_valid_i)
    else $error("response appeared without finished work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_data_i)))
    else $error("stalled response word changed or dropped");

endmodule

bind int64_divider_signed_unsigned i64div_checker u_i64div_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

/* test/tb_int64_divider_signed_unsigned.sv */
// Self-checking testbench for the 64-bit signed/unsigned divider under varied handshake pacing.
module tb_int64_divider_signed_unsigned;
  import i64div_pkg::*;

  localparam logic ModeUnsigned = 1'b0;
  localparam logic ModeSigned   = 1'b1;
  localparam logic [DivW-1:0] AllOnes = '1;
  localparam logic [DivW-1:0] MinSigned = {1'b1, {(DivW-1){1'b0}}};
  localparam logic [DivW-1:0] MaxSigned = {1'b0, {(DivW-1){1'b1}}};
  localparam int unsigned RandPerPhase = 333;
  localparam int unsigned TailCycles = 70;
  localparam int unsigned StallLimit = 4000;

  logic clk = 1'b0;
  logic rst_n;

  i64div_req_if req_ch ();
  i64div_rsp_if rsp_ch ();

  int64_divider_signed_unsigned uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  req_t div_jobs_q[$];
  rsp_t quot_rem_q[$];
  rsp_t oldest_quot_rem;

  int unsigned src_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_signed = 0;
  int unsigned n_by_zero = 0;
  int unsigned n_checked = 0;
  int unsigned n_mismatch = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t divide_c_style(req_t job);
    rsp_t res;
    logic neg_a, neg_b;
    logic [DivW-1:0] mag_a, mag_b, quo, rem;
    res = '0;
    if (job.divisor == '0) begin
      res.div_by_zero = 1'b1;
      return res;
    end
    neg_a = (job.req_type == ModeSigned) && job.dividend[DivW-1];
    neg_b = (job.req_type == ModeSigned) && job.divisor[DivW-1];
    mag_a = neg_a ? -job.dividend : job.dividend;
    mag_b = neg_b ? -job.divisor : job.divisor;
    quo = mag_a / mag_b;
    rem = mag_a % mag_b;
    res.quotient = (neg_a != neg_b) ? -quo : quo;
    res.remainder_out = neg_a ? -rem : rem;
    return res;
  endfunction

  function automatic logic [DivW-1:0] pick_operand();
    logic [DivW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0, 1, 2: ;
      3, 4: v = v >> $urandom_range(DivW - 1);
      5: v = -(v >> $urandom_range(DivW - 1));
      6: v = DivW'($urandom_range(9));
      default: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = DivW'(1);
          2: v = AllOnes;
          3: v = MinSigned;
          default: v = MaxSigned;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_job(input logic mode, input logic [DivW-1:0] a, input logic [DivW-1:0] b);
    req_t job;
    job.req_type = mode;
    job.dividend = a;
    job.divisor = b;
    div_jobs_q.push_back(job);
  endtask

  task automatic add_random_jobs(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      add_job(logic'($urandom_range(1)), pick_operand(), pick_operand());
    end
  endtask

  task automatic wait_drained();
    while (div_jobs_q.size() != 0 || req_ch.valid || quot_rem_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string fld, input logic [DivW-1:0] want,
                             input logic [DivW-1:0] got);
    if (want !== got) begin
      if (n_mismatch < 10) begin
        $display("MISMATCH %s: expected %h, got %h", fld, want, got);
      end
      n_mismatch++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        quot_rem_q.push_back(divide_c_style(req_ch.data));
        n_sent++;
        if (req_ch.data.req_type == ModeSigned) n_signed++;
        if (req_ch.data.divisor == '0) n_by_zero++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (div_jobs_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= div_jobs_q.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (quot_rem_q.size() == 0) begin
          if (n_mismatch < 10) begin
            $display("MISMATCH unexpected word: %h", rsp_ch.data);
          end
          n_mismatch++;
        end else begin
          oldest_quot_rem = quot_rem_q.pop_front();
          check_field("quotient", oldest_quot_rem.quotient, rsp_ch.data.quotient);
          check_field("remainder_out", oldest_quot_rem.remainder_out,
                      rsp_ch.data.remainder_out);
          check_field("div_by_zero", DivW'(oldest_quot_rem.div_by_zero),
                      DivW'(rsp_ch.data.div_by_zero));
          n_checked++;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("Watchdog: no word moved for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set = '{0, 73, 0, 6};
    stall_set = '{0, 0, 73, 6};
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_job(ModeUnsigned, '0, DivW'(1));
    add_job(ModeUnsigned, AllOnes, DivW'(1));
    add_job(ModeUnsigned, AllOnes, AllOnes);
    add_job(ModeUnsigned, AllOnes, '0);
    add_job(ModeSigned, '0, '0);
    add_job(ModeSigned, AllOnes, '0);
    add_job(ModeSigned, MinSigned, AllOnes);
    add_job(ModeSigned, MinSigned, DivW'(1));
    add_job(ModeUnsigned, AllOnes, MinSigned);
    add_job(ModeUnsigned, MinSigned, DivW'(3));
    add_job(ModeUnsigned, AllOnes, MaxSigned);
    add_job(ModeSigned, DivW'(7), DivW'(2));
    add_job(ModeSigned, DivW'(7), -DivW'(2));
    add_job(ModeSigned, -DivW'(7), DivW'(2));
    add_job(ModeSigned, -DivW'(7), -DivW'(2));
    add_job(ModeUnsigned, -DivW'(7), DivW'(2));
    add_job(ModeUnsigned, DivW'(5), DivW'(7));
    add_job(ModeSigned, AllOnes, AllOnes);
    add_job(ModeSigned, MinSigned, MinSigned);
    add_job(ModeSigned, MaxSigned, MinSigned);
    add_job(ModeSigned, MaxSigned, MaxSigned);
    add_job(ModeUnsigned, DivW'(1), AllOnes);
    add_job(ModeSigned, '0, AllOnes);
    add_job(ModeSigned, MinSigned, DivW'(2));

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_set[p];
      rcv_stall_pct = stall_set[p];
      add_random_jobs(RandPerPhase);
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    $display("Checked %0d of %0d divisions: %0d signed, %0d by zero,", n_checked, n_sent,
             n_signed, n_by_zero);
    $display("over four sender/receiver pacing mixes; %0d field mismatches", n_mismatch);
    if (n_mismatch == 0 && quot_rem_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
